### src/dnsttl_pkg.sv
// Package: phase encoding, message layout constants and status codes for the TTL scanner.
`default_nettype none
package dnsttl_pkg;

  // Scan phase of the message walk
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_QNAME  = 3'd1,
    PH_QFIXED = 3'd2,
    PH_RNAME  = 3'd3,
    PH_RFIXED = 3'd4,
    PH_RDATA  = 3'd5,
    PH_DONE   = 3'd6,
    PH_QBAD   = 3'd7
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_HDR_SHORT = 2'd1,
    ST_QBAD     = 2'd2,
    ST_NO_TTL   = 2'd3
  } status_t;

  localparam logic [3:0]  HDR_LAST_IDX = 4'd11;    // index of the final header byte
  localparam logic [3:0]  QFIX_LEN     = 4'd4;     // type and class after a question name
  localparam logic [3:0]  RFIX_LEN     = 4'd10;    // type, class, TTL, rdlength
  localparam logic [15:0] TYPE_OPT     = 16'd41;
  localparam logic [31:0] TTL_DEFAULT  = 32'd86400;

endpackage
`default_nettype wire

### src/dns_response_min_ttl_scan.sv
// Top level: byte-stream DNS response walker; reports least non-OPT record TTL, capped at ceiling.
// A last byte passes the input register, then its result is held in the result register.
// Throughput: one message byte per cycle, but a last byte waits for a free result register;
// the per-byte update is counter and compare logic from input to state/result registers.
// Reset (rst_n low, synchronous): scan state cleared to header phase, ceiling = 86400,
// both pipeline registers emptied. After each last byte the scan state returns to reset.
`default_nettype none
module dns_response_min_ttl_scan (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  wire logic        in_tlast,   // last_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] min_ttl
  output logic [1:0]       out_tuser,  // [1:0] scan_status
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data // ttl_ceiling
);
  import dnsttl_pkg::*;

  // input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  // configuration
  logic [31:0] ceil_r;

  // scan state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic [15:0] qleft_r, qleft_nxt;
  logic [17:0] rleft_r, rleft_nxt;
  logic [5:0]  lbl_r, lbl_nxt;
  logic [3:0]  ffi_r, ffi_nxt;
  logic [15:0] rtype_r, rtype_nxt;
  logic [31:0] rttl_r, rttl_nxt;
  logic [15:0] rdata_r, rdata_nxt;
  logic [31:0] least_r, least_nxt;
  logic        have_r, have_nxt;
  logic        stopped_r, stopped_nxt;

  // result register
  logic        out_valid_r;
  logic [31:0] out_ttl_r;
  logic [1:0]  out_status_r;

  // stage handshake
  logic        out_free;
  logic        stage_adv;
  logic        take_rec;
  logic        rttl_gt_ceil;
  logic        least_gt_ceil;
  logic        gt_sel;
  logic [31:0] res_ttl;
  logic [1:0]  res_status;

  assign out_free  = !out_valid_r || out_tready;
  assign stage_adv = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || stage_adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_ttl_r;
  assign out_tuser  = out_status_r;

  // ceiling compares run beside the state update
  assign rttl_gt_ceil  = rttl_r > ceil_r;
  assign least_gt_ceil = least_r > ceil_r;

  // next scan state for the byte in the input register
  always_comb begin
    phase_nxt   = phase_r;
    hidx_nxt    = hidx_r;
    qleft_nxt   = qleft_r;
    rleft_nxt   = rleft_r;
    lbl_nxt     = lbl_r;
    ffi_nxt     = ffi_r;
    rtype_nxt   = rtype_r;
    rttl_nxt    = rttl_r;
    rdata_nxt   = rdata_r;
    least_nxt   = least_r;
    have_nxt    = have_r;
    stopped_nxt = stopped_r;
    take_rec    = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        case (hidx_r)
          4'd4: qleft_nxt = {in_byte_r, 8'h00};
          4'd5: qleft_nxt = qleft_r | {8'h00, in_byte_r};
          4'd6, 4'd8, 4'd10: rtype_nxt = {in_byte_r, 8'h00};
          4'd7, 4'd9, 4'd11: begin
            rleft_nxt = rleft_r + {2'b00, rtype_r | {8'h00, in_byte_r}};
            rtype_nxt = '0;
          end
          default: ;
        endcase
        hidx_nxt = hidx_r + 4'd1;
        if (hidx_r == HDR_LAST_IDX) begin
          lbl_nxt = '0;
          if (qleft_nxt != '0) begin
            phase_nxt = PH_QNAME;
          end else begin
            phase_nxt = (rleft_nxt != '0) ? PH_RNAME : PH_DONE;
          end
        end
      end
      PH_QNAME, PH_RNAME: begin
        if (lbl_r != '0) begin
          lbl_nxt = lbl_r - 6'd1;
        end else if (in_byte_r == 8'h00) begin
          ffi_nxt   = (phase_r == PH_QNAME) ? QFIX_LEN : RFIX_LEN;
          phase_nxt = (phase_r == PH_QNAME) ? PH_QFIXED : PH_RFIXED;
        end else if (in_byte_r[7:6] == 2'b11) begin
          // pointer: one more byte, then the fixed part
          ffi_nxt   = ((phase_r == PH_QNAME) ? QFIX_LEN : RFIX_LEN) + 4'd1;
          phase_nxt = (phase_r == PH_QNAME) ? PH_QFIXED : PH_RFIXED;
        end else if (in_byte_r[7:6] != 2'b00) begin
          if (phase_r == PH_QNAME) begin
            phase_nxt = PH_QBAD;
          end else begin
            stopped_nxt = 1'b1;
            phase_nxt   = PH_DONE;
          end
        end else begin
          lbl_nxt = in_byte_r[5:0];
        end
      end
      PH_QFIXED: begin
        ffi_nxt = ffi_r - 4'd1;
        if (ffi_nxt == '0) begin
          qleft_nxt = qleft_r - 16'd1;
          lbl_nxt   = '0;
          if (qleft_nxt != '0) begin
            phase_nxt = PH_QNAME;
          end else begin
            phase_nxt = (rleft_r != '0) ? PH_RNAME : PH_DONE;
          end
        end
      end
      PH_RFIXED: begin
        case (ffi_r)
          4'd10: rtype_nxt = {in_byte_r, 8'h00};
          4'd9:  rtype_nxt = rtype_r | {8'h00, in_byte_r};
          4'd6, 4'd5, 4'd4, 4'd3: rttl_nxt = {rttl_r[23:0], in_byte_r};
          4'd2:  rdata_nxt = {in_byte_r, 8'h00};
          4'd1:  rdata_nxt = rdata_r | {8'h00, in_byte_r};
          default: ;
        endcase
        ffi_nxt = ffi_r - 4'd1;
        if (ffi_nxt == '0) begin
          if (rdata_nxt == '0) begin
            take_rec = 1'b1;
          end else begin
            phase_nxt = PH_RDATA;
          end
        end
      end
      PH_RDATA: begin
        rdata_nxt = rdata_r - 16'd1;
        if (rdata_nxt == '0) begin
          take_rec = 1'b1;
        end
      end
      default: ;
    endcase

    // close a complete record
    gt_sel = least_gt_ceil;
    if (take_rec) begin
      if (rtype_r != TYPE_OPT) begin
        if (!have_r || (rttl_r < least_r)) begin
          least_nxt = rttl_r;
          gt_sel    = rttl_gt_ceil;
        end
        have_nxt = 1'b1;
      end
      rleft_nxt = rleft_r - 18'd1;
      lbl_nxt   = '0;
      phase_nxt = (rleft_nxt != '0) ? PH_RNAME : PH_DONE;
    end

    // result for a last byte
    res_ttl    = '0;
    res_status = ST_NO_TTL;
    case (phase_nxt) inside
      PH_HEADER: res_status = ST_HDR_SHORT;
      PH_QNAME, PH_QFIXED, PH_QBAD: res_status = ST_QBAD;
      default: begin
        if (have_nxt) begin
          res_ttl = gt_sel ? ceil_r : least_nxt;
        end
        res_status = (res_ttl != '0) ? ST_FOUND : ST_NO_TTL;
      end
    endcase
  end

  // hold the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // ceiling register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r <= TTL_DEFAULT;
    end else if (cfg_wr_en) begin
      ceil_r <= cfg_wr_data;
    end
  end

  // advance scan state; drop back to reset state after a last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (stage_adv && in_last_r)) begin
      phase_r   <= PH_HEADER;
      hidx_r    <= '0;
      qleft_r   <= '0;
      rleft_r   <= '0;
      lbl_r     <= '0;
      ffi_r     <= '0;
      rtype_r   <= '0;
      rttl_r    <= '0;
      rdata_r   <= '0;
      least_r   <= '0;
      have_r    <= 1'b0;
      stopped_r <= 1'b0;
    end else if (stage_adv) begin
      phase_r   <= phase_nxt;
      hidx_r    <= hidx_nxt;
      qleft_r   <= qleft_nxt;
      rleft_r   <= rleft_nxt;
      lbl_r     <= lbl_nxt;
      ffi_r     <= ffi_nxt;
      rtype_r   <= rtype_nxt;
      rttl_r    <= rttl_nxt;
      rdata_r   <= rdata_nxt;
      least_r   <= least_nxt;
      have_r    <= have_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_adv && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (stage_adv && in_last_r) begin
      out_ttl_r    <= res_ttl;
      out_status_r <= res_status;
    end
  end

endmodule
`default_nettype wire
